@@ rtl/deq_pkg.sv @@
// Package for the double-ended queue with min/max report.
// Holds the item types, command and status codes, and the sequencer states.
// Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 5;
	localparam int DEPTH_DEF = 16;

	// Command codes carried by an input item; other codes act as report only.
	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REPORT     = 3'd4
	} deq_cmd_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} deq_status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} deq_state_t;

	typedef struct packed {
		logic [2:0]               cmd;
		logic signed [DATA_W-1:0] value;
	} deq_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [COUNT_W-1:0]       count;
		logic                     is_empty;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic signed [DATA_W-1:0] largest;
		logic signed [DATA_W-1:0] smallest;
	} deq_rsp_t;

	// Tags that travel with each scan read.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} deq_scan_ctl_t;

endpackage

`default_nettype wire

@@ rtl/deq_ram.sv @@
// Ring store of the deque: one write port, one read port, registered read data.
// Depends on deq_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [AW-1:0]                    waddr,
	input  wire logic signed [deq_pkg::DATA_W-1:0] wdata,
	input  wire logic                             re,
	input  wire logic [AW-1:0]                    raddr,
	output logic signed [deq_pkg::DATA_W-1:0]     rdata
);

	logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/deq_scan.sv @@
// Accumulator for the scan: picks the front, back, largest and smallest
// values out of the read data stream. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_scan (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire deq_pkg::deq_scan_ctl_t            ctl,
	input  wire logic signed [deq_pkg::DATA_W-1:0] rdata,
	output logic signed [deq_pkg::DATA_W-1:0]      front_q,
	output logic signed [deq_pkg::DATA_W-1:0]      back_q,
	output logic signed [deq_pkg::DATA_W-1:0]      big_q,
	output logic signed [deq_pkg::DATA_W-1:0]      small_q
);

	deq_pkg::deq_scan_ctl_t ctl_s1;

	// Register the tags so that they line up with the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	// The first entry seeds both extremes; later entries refine them.
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			if (ctl_s1.first) begin
				front_q <= rdata;
				big_q   <= rdata;
				small_q <= rdata;
			end else begin
				if (rdata > big_q) begin
					big_q <= rdata;
				end
				if (rdata < small_q) begin
					small_q <= rdata;
				end
			end
			if (ctl_s1.last) begin
				back_q <= rdata;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/deq_ctrl.sv @@
// Sequencer of the deque: applies a command to the front pointer and count,
// writes pushed values and walks the stored entries. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int PW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire deq_pkg::deq_req_t                 req,
	input  wire logic                              out_free,
	output logic                                   done,
	output logic [1:0]                             status_q,
	output logic [CW-1:0]                          cnt_q,
	output logic                                   we,
	output logic [PW-1:0]                          waddr,
	output logic                                   re,
	output logic [PW-1:0]                          raddr,
	output deq_pkg::deq_scan_ctl_t                 scan_ctl
);

	localparam int SW = CW + 1;

	deq_pkg::deq_state_t state_q, state_d;
	logic [PW-1:0] fp_q, fp_d;
	logic [CW-1:0] cnt_d;
	logic [1:0]    status_d;
	logic [PW-1:0] rp_q, rp_d;
	logic [PW-1:0] off_q, off_d;
	logic          accept;
	logic          full, empty;
	logic [SW-1:0] back_sum;
	logic [PW-1:0] back_slot;
	logic [PW-1:0] fp_dec, fp_inc, rp_inc;
	logic          last;

	assign accept = req_valid && !req_stall;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);

	// Ring index arithmetic with wraparound.
	always_comb begin
		back_sum = SW'(fp_q) + SW'(cnt_q);
		if (back_sum >= SW'(DEPTH)) begin
			back_sum = back_sum - SW'(DEPTH);
		end
		back_slot = PW'(back_sum);
		fp_dec    = (fp_q == '0) ? PW'(DEPTH - 1) : fp_q - 1'b1;
		fp_inc    = (fp_q == PW'(DEPTH - 1)) ? '0 : fp_q + 1'b1;
		rp_inc    = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
		last      = (off_q == PW'(cnt_q - 1'b1));
	end

	// Next state, command decode and memory control.
	always_comb begin
		state_d   = state_q;
		fp_d      = fp_q;
		cnt_d     = cnt_q;
		status_d  = status_q;
		rp_d      = rp_q;
		off_d     = off_q;
		req_stall = 1'b1;
		done      = 1'b0;
		we        = 1'b0;
		waddr     = back_slot;
		re        = 1'b0;
		raddr     = rp_q;
		scan_ctl  = '0;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (accept) begin
					status_d = deq_pkg::ST_OK;
					unique case (req.cmd)
						deq_pkg::CMD_PUSH_BACK: begin
							if (full) begin
								status_d = deq_pkg::ST_PUSH_FULL;
							end else begin
								we    = 1'b1;
								waddr = back_slot;
								cnt_d = cnt_q + 1'b1;
							end
						end
						deq_pkg::CMD_PUSH_FRONT: begin
							if (full) begin
								status_d = deq_pkg::ST_PUSH_FULL;
							end else begin
								we    = 1'b1;
								waddr = fp_dec;
								fp_d  = fp_dec;
								cnt_d = cnt_q + 1'b1;
							end
						end
						deq_pkg::CMD_POP_FRONT: begin
							if (empty) begin
								status_d = deq_pkg::ST_POP_EMPTY;
							end else begin
								fp_d  = fp_inc;
								cnt_d = cnt_q - 1'b1;
							end
						end
						deq_pkg::CMD_POP_BACK: begin
							if (empty) begin
								status_d = deq_pkg::ST_POP_EMPTY;
							end else begin
								cnt_d = cnt_q - 1'b1;
							end
						end
						default: begin
						end
					endcase
					rp_d    = fp_d;
					off_d   = '0;
					state_d = (cnt_d == '0) ? deq_pkg::S_DONE : deq_pkg::S_SCAN;
				end
			end
			deq_pkg::S_SCAN: begin
				re             = 1'b1;
				scan_ctl.valid = 1'b1;
				scan_ctl.first = (off_q == '0);
				scan_ctl.last  = last;
				rp_d           = rp_inc;
				off_d          = off_q + 1'b1;
				if (last) begin
					state_d = deq_pkg::S_DRAIN;
				end
			end
			deq_pkg::S_DRAIN: begin
				state_d = deq_pkg::S_DONE;
			end
			deq_pkg::S_DONE: begin
				done = 1'b1;
				if (out_free) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= deq_pkg::S_IDLE;
			fp_q     <= '0;
			cnt_q    <= '0;
			status_q <= deq_pkg::ST_OK;
			rp_q     <= '0;
			off_q    <= '0;
		end else begin
			state_q  <= state_d;
			fp_q     <= fp_d;
			cnt_q    <= cnt_d;
			status_q <= status_d;
			rp_q     <= rp_d;
			off_q    <= off_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/double_ended_queue_minmax.sv @@
// Bounded double-ended queue of signed 32-bit values with min/max report.
// Instantiates deq_ctrl, deq_ram and deq_scan; depends on deq_pkg.
//
// Each item carries a command (push back, push front, pop front, pop back,
// report) and yields one result item with status, count, front and back
// values and the largest and smallest stored values, all zero when empty.
// The values live in a single-port-read ring memory, and after every command
// the stored entries are read back one per cycle to find the extremes. The
// result is offered once the scan and its last read are through, and with no
// scan at all when the deque ends up empty. One item is worked on at a time;
// the result sits in an output register, so a stall at the output holds back
// the next item only once its work is done.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_minmax #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire deq_pkg::deq_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output deq_pkg::deq_rsp_t      rsp
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                              out_free;
	logic                              done;
	logic [1:0]                        status;
	logic [CW-1:0]                     cnt;
	logic                              we, re;
	logic [PW-1:0]                     waddr, raddr;
	logic signed [deq_pkg::DATA_W-1:0] rdata;
	logic signed [deq_pkg::DATA_W-1:0] front, back, big, small_v;
	deq_pkg::deq_scan_ctl_t            scan_ctl;
	logic                              rsp_valid_q;
	deq_pkg::deq_rsp_t                 rsp_q;
	logic                              is_empty;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign is_empty = (cnt == '0);

	deq_ctrl #(
		.DEPTH(DEPTH),
		.PW(PW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.out_free(out_free),
		.done(done),
		.status_q(status),
		.cnt_q(cnt),
		.we(we),
		.waddr(waddr),
		.re(re),
		.raddr(raddr),
		.scan_ctl(scan_ctl)
	);

	deq_ram #(
		.DEPTH(DEPTH),
		.AW(PW)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(req.value),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	deq_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(scan_ctl),
		.rdata(rdata),
		.front_q(front),
		.back_q(back),
		.big_q(big),
		.small_q(small_v)
	);

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= done;
		end
	end

	// Output register: result item, zeros in the value fields when empty.
	always_ff @(posedge clk) begin
		if (out_free && done) begin
			rsp_q.status      <= status;
			rsp_q.count       <= deq_pkg::COUNT_W'(cnt);
			rsp_q.is_empty    <= is_empty;
			rsp_q.front_value <= is_empty ? '0 : front;
			rsp_q.back_value  <= is_empty ? '0 : back;
			rsp_q.largest     <= is_empty ? '0 : big;
			rsp_q.smallest    <= is_empty ? '0 : small_v;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ bench/tb_double_ended_queue_minmax.sv @@
// Self-checking bench for the double-ended queue with min/max report.
// Drives command items, predicts every result item and checks it field by field.
// Depends on deq_pkg and double_ended_queue_minmax only.
`timescale 1ns / 1ps

module tb_double_ended_queue_minmax;

	import deq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// Idle and stall odds in percent, indexed by idling phase:
	// none, sender idles, receiver stalls, both.
	localparam logic [3:0][7:0] SEND_IDLE  = {8'd19, 8'd0, 8'd62, 8'd0};
	localparam logic [3:0][7:0] RECV_STALL = {8'd19, 8'd62, 8'd0, 8'd0};

	typedef struct {
		deq_req_t op;
		int       phase;
		bit       drain_first;
	} pending_op_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	deq_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	deq_rsp_t rsp;

	pending_op_t pending_ops[$];
	deq_rsp_t    expected_reports[$];

	// Private copy of the deque contents used for prediction.
	logic signed [DATA_W-1:0] shadow_ring [DEPTH];
	int shadow_front = 0;
	int shadow_count = 0;

	int  cur_phase = 0;
	int  gen_phase = 0;
	bit  gen_drain = 1'b0;
	int  n_errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_full_refusals = 0;
	int  n_empty_refusals = 0;
	int  n_at_capacity = 0;

	double_ended_queue_minmax #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Reset is held from time zero and released on a falling edge, between rising edges.
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Applies one command to the shadow deque and returns the report it should produce.
	function automatic deq_rsp_t deque_apply(deq_req_t it);
		deq_rsp_t                 r;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] hi_val;
		logic signed [DATA_W-1:0] lo_val;
		int                       k;
		r = '0;
		r.status = ST_OK;
		case (it.cmd)
			CMD_PUSH_BACK: begin
				if (shadow_count == DEPTH) begin
					r.status = ST_PUSH_FULL;
				end else begin
					shadow_ring[(shadow_front + shadow_count) % DEPTH] = it.value;
					shadow_count++;
				end
			end
			CMD_PUSH_FRONT: begin
				if (shadow_count == DEPTH) begin
					r.status = ST_PUSH_FULL;
				end else begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_ring[shadow_front] = it.value;
					shadow_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (shadow_count == 0) begin
					r.status = ST_POP_EMPTY;
				end else begin
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end
			end
			CMD_POP_BACK: begin
				if (shadow_count == 0) begin
					r.status = ST_POP_EMPTY;
				end else begin
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(shadow_count);
		r.is_empty = (shadow_count == 0);
		if (shadow_count > 0) begin
			hi_val = shadow_ring[shadow_front];
			lo_val = hi_val;
			for (k = 1; k < shadow_count; k++) begin
				v = shadow_ring[(shadow_front + k) % DEPTH];
				if (v > hi_val) hi_val = v;
				if (v < lo_val) lo_val = v;
			end
			r.front_value = shadow_ring[shadow_front];
			r.back_value = shadow_ring[(shadow_front + shadow_count - 1) % DEPTH];
			r.largest = hi_val;
			r.smallest = lo_val;
		end
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= 40)
				$display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
		end
	endtask

	task automatic queue_op(input logic [2:0] c, input logic signed [DATA_W-1:0] v);
		pending_op_t p;
		p.op.cmd = c;
		p.op.value = v;
		p.phase = gen_phase;
		p.drain_first = gen_drain;
		gen_drain = 1'b0;
		pending_ops.insert(pending_ops.size(), p);
	endtask

	// Mix of extremes, near-zero values that repeat often, and full-range values.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -1;
			4, 5: return $signed($urandom_range(20)) - 10;
			default: return $urandom();
		endcase
	endfunction

	// Command mix biased toward filling (mode 0), draining (mode 1) or neither (mode 2).
	function automatic logic [2:0] pick_cmd(int mode);
		int roll;
		int push_share;
		roll = $urandom_range(99);
		push_share = (mode == 0) ? 76 : (mode == 1) ? 20 : 48;
		if (roll < push_share / 2) return CMD_PUSH_BACK;
		if (roll < push_share) return CMD_PUSH_FRONT;
		if (roll < push_share + (96 - push_share) / 2) return CMD_POP_FRONT;
		if (roll < 96) return CMD_POP_BACK;
		return 3'($urandom_range(CMD_REPORT, 7));
	endfunction

	// Driver: offers the next pending item and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin : p_drive
		bit accepted;
		bit offer;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			accepted = req_valid && !req_stall;
			if (accepted) begin
				expected_reports.insert(expected_reports.size(), deque_apply(req));
				n_sent++;
			end
			if (!req_valid || accepted) begin
				offer = 1'b0;
				if (pending_ops.size() != 0) begin
					if ($urandom_range(99) >= SEND_IDLE[pending_ops[0].phase] &&
					    (!pending_ops[0].drain_first || expected_reports.size() == 0))
						offer = 1'b1;
				end
				if (offer) begin
					req <= pending_ops[0].op;
					cur_phase = pending_ops[0].phase;
					void'(pending_ops.pop_front());
				end
				req_valid <= offer;
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : p_watch
		deq_rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_reports.size() == 0) begin
					n_errors++;
					if (n_errors <= 40)
						$display("%0t ns: result with no item outstanding, expected none, actual %h",
							$time, rsp);
				end else begin
					want = expected_reports.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("count", want.count, rsp.count);
					check_field("is_empty", want.is_empty, rsp.is_empty);
					check_field("front_value", want.front_value, rsp.front_value);
					check_field("back_value", want.back_value, rsp.back_value);
					check_field("largest", want.largest, rsp.largest);
					check_field("smallest", want.smallest, rsp.smallest);
					n_checked++;
					if (want.status == ST_PUSH_FULL) n_full_refusals++;
					if (want.status == ST_POP_EMPTY) n_empty_refusals++;
					if (want.count == DEPTH) n_at_capacity++;
				end
			end
			rsp_stall <= ($urandom_range(99) < RECV_STALL[cur_phase]);
		end
	end

	// Stimulus: a directed opening, then random phases that each start from a drained block.
	initial begin : p_stim
		int ph;
		int n;
		int mode;
		int k;
		mode = 2;
		// Empty deque: reports and refused pops, including an unused command code.
		queue_op(CMD_REPORT, 32'sh12345678);
		queue_op(CMD_POP_FRONT, -1);
		queue_op(CMD_POP_BACK, 32'sh7fffffff);
		queue_op(3'd7, '0);
		// Extreme values at both ends; unused codes must leave the contents alone.
		queue_op(CMD_PUSH_BACK, 32'sh7fffffff);
		queue_op(CMD_PUSH_FRONT, 32'sh80000000);
		queue_op(3'd5, 32'sh55555555);
		queue_op(3'd6, 32'shaaaaaaaa);
		queue_op(CMD_POP_BACK, '0);
		queue_op(CMD_PUSH_BACK, '0);
		queue_op(CMD_PUSH_FRONT, -1);
		// Fill to capacity, push on full at both ends, then pop one from each end.
		for (k = 0; k < DEPTH - 3; k++)
			queue_op((k % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, k * 37 - 200);
		queue_op(CMD_PUSH_BACK, 32'sh11111111);
		queue_op(CMD_PUSH_FRONT, 32'sh22222222);
		queue_op(CMD_POP_FRONT, '0);
		queue_op(CMD_POP_BACK, '0);

		for (ph = 0; ph < 5; ph++) begin
			gen_phase = ph % 4;
			gen_drain = 1'b1;
			for (n = 0; n < 170; n++) begin
				if (n % 40 == 0) mode = $urandom_range(2);
				queue_op(pick_cmd(mode), pick_value());
			end
		end

		while (pending_ops.size() != 0 || req_valid) @(posedge clk);
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);

		$display("Sent %0d items over four idling patterns, checked %0d results.",
			n_sent, n_checked);
		$display("Refused pushes on full: %0d, refused pops on empty: %0d, results at capacity: %0d.",
			n_full_refusals, n_empty_refusals, n_at_capacity);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Timed out with %0d items pending and %0d results outstanding.",
			pending_ops.size(), expected_reports.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
